[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro places one labeled
// concurrent assertion that is checked on the rising clock edge and is
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/nca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest centroid assignment package
// Field widths, action and state codes, and the command and status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nca_pkg;

   localparam int ACTION_W    = 2;
   localparam int CLONE_IDX_W = 5;
   localparam int SAMPLE_W    = 6;
   localparam int FREQ_W      = 16;
   localparam int SQ_W        = 32;
   localparam int SUM_W       = 38;
   localparam int TOTAL_W     = 48;
   localparam int CSR_W       = 6;

   localparam logic [CSR_W-1:0] CLONES_RESET = 6'd32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_TOTAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_total;
      logic capture;
      logic issue;
      logic total;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic issue_last;
      logic pass_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[rtl/core/nca_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one load, sample or clear word.
// ----------------------------------------------------------------------------
interface nca_req_if;
   import nca_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ACTION_W-1:0]    action;
   logic [CLONE_IDX_W-1:0] clone_index;
   logic [SAMPLE_W-1:0]    sample_index;
   logic [FREQ_W-1:0]      freq_value;
   logic                   last_sample;

   modport source (
      output valid, action, clone_index, sample_index, freq_value, last_sample,
      input  ready
   );

   modport sink (
      input  valid, action, clone_index, sample_index, freq_value, last_sample,
      output ready
   );
endinterface
`default_nettype wire

[rtl/core/nca_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one assignment word per finished variant.
// ----------------------------------------------------------------------------
interface nca_rsp_if;
   import nca_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CLONE_IDX_W-1:0] best_clone;
   logic [SUM_W-1:0]       best_error;
   logic [TOTAL_W-1:0]     total_error;

   modport source (
      output valid, best_clone, best_error, total_error,
      input  ready
   );

   modport sink (
      input  valid, best_clone, best_error, total_error,
      output ready
   );
endinterface
`default_nettype wire

[rtl/core/nca_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/nca_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Nearest centroid controller
// Accepts request words, sequences the per-centroid pass over the datapath
// and schedules the total update and the response word.
// ----------------------------------------------------------------------------
module nca_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nca_pkg::ACTION_W-1:0]  req_action,
   input  logic                          req_last_sample,
   input  nca_pkg::status_type           status,
   output nca_pkg::cmd_type              cmd
);
   import nca_pkg::*;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (action_type'(req_action))
                  ACT_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  ACT_SAMPLE: begin
                     cmd.capture = 1'b1;
                     last_in     = req_last_sample;
                     state_in    = ST_ISSUE;
                  end
                  ACT_CLEAR: begin
                     cmd.clear_total = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pass_done) begin
               state_in = last_ff ? ST_TOTAL : ST_IDLE;
            end
         end
         ST_TOTAL: begin
            cmd.total = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `NCA_ASSERT_SAME(a_emit_needs_room, clock, reset, cmd.emit, status.out_free, "emit while output full")
   `NCA_ASSERT_NEXT(a_last_pass_totals, clock, reset, (state_ff == ST_DRAIN) && status.pass_done && last_ff, cmd.total, "finished variant skipped the total update")
   `NCA_ASSERT_SAME(a_issue_alone, clock, reset, cmd.issue, !req_ready && !cmd.emit && !cmd.total, "issue overlaps another command")

endmodule
`default_nettype wire

[rtl/core/nca_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Nearest centroid datapath
// Centroid table, per-centroid error sums, the squared-difference pipeline,
// the argmin tracker, the running total and the response register.
// ----------------------------------------------------------------------------
module nca_dpath #(
   parameter int MAX_CLONES  = 32,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  nca_pkg::cmd_type                 cmd,
   output nca_pkg::status_type              status,
   input  logic [nca_pkg::CLONE_IDX_W-1:0]  req_clone_index,
   input  logic [nca_pkg::SAMPLE_W-1:0]     req_sample_index,
   input  logic [nca_pkg::FREQ_W-1:0]       req_freq_value,
   input  logic                             csr_wr_en,
   input  logic [nca_pkg::CSR_W-1:0]        csr_wr_data,
   nca_rsp_if.source                        rsp_if
);
   import nca_pkg::*;

   localparam int CW  = $clog2(MAX_CLONES);
   localparam int TD  = MAX_CLONES * MAX_SAMPLES;
   localparam int TAW = $clog2(TD);
   localparam int LW  = (CW + 1 > CSR_W) ? CW + 1 : CSR_W;

   // Clone count register and the index of the last active clone.
   logic [CSR_W-1:0] csr_ff;
   logic [LW-1:0]    active_n;
   logic [CW-1:0]    last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CLONES_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (csr_ff == '0) begin
         active_n = LW'(1);
      end else if (csr_ff > MAX_CLONES) begin
         active_n = LW'(MAX_CLONES);
      end else begin
         active_n = LW'(csr_ff);
      end
      last_idx = CW'(active_n - LW'(1));
   end

   // Captured sample word. An out-of-range sample reads entry zero and adds nothing.
   logic [FREQ_W-1:0]   freq_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                in_range_ff;
   logic                req_in_range;

   assign req_in_range = (req_sample_index < MAX_SAMPLES);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         freq_ff     <= req_freq_value;
         sample_ff   <= req_in_range ? req_sample_index : '0;
         in_range_ff <= req_in_range;
      end
   end

   // Clone counter for the issue stage.
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         cnt_in = '0;
      end else if (cmd.issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Centroid table.
   logic             tbl_wr_en;
   logic [TAW-1:0]   tbl_wr_addr;
   logic [TAW-1:0]   tbl_rd_addr;
   logic [FREQ_W-1:0] tbl_rd_data;

   assign tbl_wr_en   = cmd.load && (req_clone_index < MAX_CLONES) && req_in_range;
   assign tbl_wr_addr = TAW'(req_clone_index) * TAW'(MAX_SAMPLES) + TAW'(req_sample_index);
   assign tbl_rd_addr = TAW'(cnt_ff) * TAW'(MAX_SAMPLES) + TAW'(sample_ff);

   nca_ram #(
      .WIDTH (FREQ_W),
      .DEPTH (TD)
   ) u_tbl (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_freq_value),
      .rd_en   (cmd.issue),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // Per-clone error sums. A clone whose valid bit is clear reads as zero.
   logic [SUM_W-1:0]     sum_rd_data;
   logic [SUM_W-1:0]     sum_wr_data;
   logic [MAX_CLONES-1:0] sum_valid_ff;

   // Pipeline registers.
   logic              p1_valid_ff, p1_first_ff, p1_last_ff;
   logic [CW-1:0]     p1_clone_ff;
   logic              p2_valid_ff, p2_first_ff, p2_last_ff;
   logic [CW-1:0]     p2_clone_ff;
   logic [FREQ_W-1:0] p2_diff_ff;
   logic [SUM_W-1:0]  p2_sum_ff;
   logic              p3_valid_ff, p3_first_ff, p3_last_ff;
   logic [CW-1:0]     p3_clone_ff;
   logic [SQ_W-1:0]   p3_sq_ff;
   logic [SUM_W-1:0]  p3_sum_ff;
   logic              p4_valid_ff, p4_first_ff, p4_last_ff;
   logic [CW-1:0]     p4_clone_ff;
   logic [SUM_W-1:0]  p4_sum_ff;

   nca_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_CLONES)
   ) u_sums (
      .clock   (clock),
      .wr_en   (p3_valid_ff),
      .wr_addr (p3_clone_ff),
      .wr_data (sum_wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (cnt_ff),
      .rd_data (sum_rd_data)
   );

   logic [FREQ_W-1:0] diff;
   logic [SUM_W-1:0]  sum_old;
   logic [SUM_W:0]    sum_wide;

   always_comb begin
      if (!in_range_ff) begin
         diff = '0;
      end else if (freq_ff >= tbl_rd_data) begin
         diff = freq_ff - tbl_rd_data;
      end else begin
         diff = tbl_rd_data - freq_ff;
      end
      sum_old     = sum_valid_ff[p1_clone_ff] ? sum_rd_data : '0;
      sum_wide    = {1'b0, p3_sum_ff} + (SUM_W + 1)'(p3_sq_ff);
      sum_wr_data = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.issue;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_clone_ff <= cnt_ff;
      p1_first_ff <= (cnt_ff == '0);
      p1_last_ff  <= (cnt_ff == last_idx);
      p2_clone_ff <= p1_clone_ff;
      p2_first_ff <= p1_first_ff;
      p2_last_ff  <= p1_last_ff;
      p2_diff_ff  <= diff;
      p2_sum_ff   <= sum_old;
      p3_clone_ff <= p2_clone_ff;
      p3_first_ff <= p2_first_ff;
      p3_last_ff  <= p2_last_ff;
      p3_sq_ff    <= SQ_W'(p2_diff_ff) * SQ_W'(p2_diff_ff);
      p3_sum_ff   <= p2_sum_ff;
      p4_clone_ff <= p3_clone_ff;
      p4_first_ff <= p3_first_ff;
      p4_last_ff  <= p3_last_ff;
      p4_sum_ff   <= sum_wr_data;
   end

   // Finishing a variant zeroes every sum at once by dropping the valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= '0;
      end else if (cmd.total) begin
         sum_valid_ff <= '0;
      end else if (p3_valid_ff) begin
         sum_valid_ff[p3_clone_ff] <= 1'b1;
      end
   end

   // Argmin over the updated sums. Clones arrive in increasing order, so a
   // strict compare keeps the lowest index on ties.
   logic [SUM_W-1:0] best_err_ff;
   logic [CW-1:0]    best_idx_ff;

   always_ff @(posedge clock) begin
      if (p4_valid_ff && (p4_first_ff || (p4_sum_ff < best_err_ff))) begin
         best_err_ff <= p4_sum_ff;
         best_idx_ff <= p4_clone_ff;
      end
   end

   // Running total with saturation.
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W:0]   total_wide;

   assign total_wide = {1'b0, total_ff} + (TOTAL_W + 1)'(best_err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.clear_total) begin
         total_ff <= '0;
      end else if (cmd.total) begin
         total_ff <= total_wide[TOTAL_W] ? '1 : total_wide[TOTAL_W-1:0];
      end
   end

   // Response register. It frees up in the same cycle the word is taken.
   logic                   rsp_valid_ff;
   logic [CLONE_IDX_W-1:0] rsp_clone_ff;
   logic [SUM_W-1:0]       rsp_err_ff;
   logic [TOTAL_W-1:0]     rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_clone_ff <= CLONE_IDX_W'(best_idx_ff);
         rsp_err_ff   <= best_err_ff;
         rsp_total_ff <= total_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.best_clone  = rsp_clone_ff;
   assign rsp_if.best_error  = rsp_err_ff;
   assign rsp_if.total_error = rsp_total_ff;

   assign status.issue_last = (cnt_ff == last_idx);
   assign status.pass_done  = p4_valid_ff && p4_last_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_if.ready;

   `NCA_ASSERT_SAME(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(cmd.emit),
                    "response raised without emit")
   `NCA_ASSERT_NEXT(a_total_grows, clock, reset, !cmd.clear_total,
                    total_ff >= $past(total_ff), "running total decreased without clear")
   `NCA_ASSERT_SAME(a_sum_write_in_pass, clock, reset, p3_valid_ff,
                    !cmd.total && !cmd.capture, "sum write outside a pass")

endmodule
`default_nettype wire

[rtl/core/nearest_centroid_assign.sv]
`timescale 1ns / 1ps
`default_nettype none
// Usage: words arrive on req_if (valid/ready). A load word (action 0) writes one
// centroid value and a clear word (action 2) zeroes the running total. A sample
// word (action 1) adds the squared difference to every active centroid, one
// centroid per cycle through a four-stage pipeline, and occupies the block until
// the last centroid's sum has passed through the pipeline.
// A sample word with last_sample set then adds the best error to the running
// total and loads the response register, which raises rsp_if.valid carrying
// the best centroid, its error and the running total.
// The response register lets the next words be accepted while a response
// waits. If rsp_if.ready stays low, the next finished variant holds in its last
// step and req_if.ready stays low until the waiting word is taken.
// csr_wr_en/csr_wr_data set the number of centroids in use; write it only while
// the block is idle. Reset sets it to 32, clears the running total, the
// per-centroid sums and the response valid. The centroid table is not cleared
// and must be loaded before use.
// ----------------------------------------------------------------------------
// Nearest centroid assignment, top level
// Controller and datapath for the k-means assignment step.
// ----------------------------------------------------------------------------
module nearest_centroid_assign #(
   parameter int MAX_CLONES  = 32,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   nca_req_if.sink                     req_if,
   nca_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [nca_pkg::CSR_W-1:0]   csr_wr_data
);
   import nca_pkg::*;

   cmd_type    cmd;
   status_type status;

   nca_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_action      (req_if.action),
      .req_last_sample (req_if.last_sample),
      .status          (status),
      .cmd             (cmd)
   );

   nca_dpath #(
      .MAX_CLONES  (MAX_CLONES),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_clone_index  (req_if.clone_index),
      .req_sample_index (req_if.sample_index),
      .req_freq_value   (req_if.freq_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_if           (rsp_if)
   );

endmodule
`default_nettype wire
